>>> src/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
package bba_pkg;

    localparam int MAX_UNITS_DEF     = 65536;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam int DATA_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int UNITS_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam int BYTE_BITS = 8;
    localparam int BYTE_LOG2 = 3;

    localparam logic [DATA_W-1:0]  BASE_RESET  = 32'h0000_0000;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic [UNITS_W-1:0] UNITS_RESET = 17'd65536;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SHIFT = 2'd1,
        CFG_UNITS = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALU_SUB     = 2'd0,
        ALU_ADD_SHL = 2'd1,
        ALU_SHR     = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [SHIFT_W-1:0]   shamt;
    } alu_ctrl_t;

endpackage

>>> src/bba_if.sv
// Handshake channel interfaces: request, response and configuration write.
interface bba_req_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    action_t           action;
    logic [DATA_W-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] unit_address;
    status_t           status;

    modport source (output valid, output unit_address, output status, input ready);
    modport sink   (input valid, input unit_address, input status, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/bitmap_block_allocator.sv
// First-fit bitmap allocator: free map memory, scan sequencer and shared ALU.
//
//  channel | dir | transfer when  | payload
//  --------+-----+----------------+---------------------------------------
//  req     | in  | valid && ready | action, address
//  rsp     | out | valid && ready | unit_address, status
//  cfg     | in  | valid && ready | index (0 base, 1 size log2, 2 units), data
//
//  Allocate: the scan reads and checks each map word in turn (one read, one check),
//  then picks the bit, forms the address and posts the result; the map
//  memory's single registered read port sets the scan pace.
//  Free: subtract, shift and range check, read, write, post.
//  One request at a time; req.ready is high only while idle, and a new request
//  may be taken while the previous result still waits on rsp.
//  No clearing pass: a fill count of touched words makes untouched words read
//  as zero, so the block is ready right after reset. cfg.ready is always high.
module bitmap_block_allocator import bba_pkg::*;
#(
    parameter int MAX_UNITS     = MAX_UNITS_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    bba_req_if.sink       req,
    bba_rsp_if.source     rsp,
    bba_cfg_if.sink       cfg
);

    // MAP_WORD_BITS must be a power of two; the block itself does not enforce it
    localparam int W        = MAP_WORD_BITS;
    localparam int DEPTH    = (MAX_UNITS + W - 1) / W;
    localparam int BIT_W    = $clog2(W);
    localparam int WORD_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UIDX_W   = WORD_W + BIT_W;
    localparam int NBYTES   = W / BYTE_BITS;
    localparam int BSEL_W   = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int UNIT_CAP = (MAX_UNITS / 8) * 8;
    localparam int CAP_W    = $clog2(UNIT_CAP + 1);
    localparam int CNT_W    = (CAP_W > UNITS_W) ? CAP_W : UNITS_W;
    localparam int HWM_W    = $clog2(DEPTH + 1);
    localparam int CMP_W    = ((UIDX_W > CNT_W) ? UIDX_W : CNT_W) + 1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN_RD  = 10'b00_0000_0010,
        S_SCAN_CHK = 10'b00_0000_0100,
        S_PICK     = 10'b00_0000_1000,
        S_ADDR     = 10'b00_0001_0000,
        S_FREE_SUB = 10'b00_0010_0000,
        S_FREE_SHR = 10'b00_0100_0000,
        S_FREE_RD  = 10'b00_1000_0000,
        S_FREE_WR  = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DATA_W-1:0]    base_reg, base_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [UNITS_W-1:0]   units_reg, units_next;
    logic [HWM_W-1:0]     hwm_reg, hwm_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]     n_reg, n_next;
    logic [DATA_W-1:0]    addr_reg, addr_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [W-1:0]         hold_reg, hold_next;
    logic [BSEL_W-1:0]    bytesel_reg, bytesel_next;
    logic [BYTE_BITS-1:0] bytebits_reg, bytebits_next;
    logic [UIDX_W-1:0]    unit_reg, unit_next;
    logic [DATA_W-1:0]    res_addr_reg, res_addr_next;
    status_t              res_status_reg, res_status_next;
    logic [DATA_W-1:0]    rsp_addr_reg, rsp_addr_next;
    status_t              rsp_status_reg, rsp_status_next;

    // free map memory
    logic [W-1:0]         map_mem [DEPTH];
    logic [W-1:0]         rdata_reg;
    logic                 live_reg;
    logic [WORD_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    wr_addr;
    logic [W-1:0]         wr_data;
    logic                 mem_we;

    logic [CNT_W-1:0]     units_masked;
    logic [CNT_W-1:0]     n_eff;
    logic [W-1:0]         eff_word;
    logic [CMP_W-1:0]     word_unit;
    logic [CMP_W-1:0]     n_cmp;
    logic [CMP_W-1:0]     scan_rem;
    logic [W-1:0]         scan_mask;
    logic [BSEL_W-1:0]    sel_byte;
    logic [BYTE_BITS-1:0] sel_bits;
    logic [BYTE_LOG2-1:0] pick_bit;
    logic [BIT_W-1:0]     pick_pos;
    logic [W-1:0]         bit_onehot;

    alu_ctrl_t            alu_ctrl;
    logic [DATA_W-1:0]    alu_a, alu_b, alu_res;
    logic                 alu_borrow;

    bba_alu u_alu
    (
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.unit_address = rsp_addr_reg;
    assign rsp.status       = rsp_status_reg;

    // effective unit count: low three bits dropped, saturated at capacity
    assign units_masked = CNT_W'(units_reg) & ~CNT_W'(7);
    assign n_eff = (units_masked > CNT_W'(UNIT_CAP)) ? CNT_W'(UNIT_CAP) : units_masked;

    assign eff_word   = live_reg ? rdata_reg : '0;
    assign word_unit  = CMP_W'({word_reg, {BIT_W{1'b0}}});
    assign n_cmp      = CMP_W'(n_reg);
    assign scan_rem   = n_cmp - word_unit;
    assign bit_onehot = W'(1) << unit_reg[BIT_W-1:0];
    assign rd_addr    = (state_reg == S_FREE_RD) ? unit_reg[UIDX_W-1:BIT_W] : word_reg;

    // keep free bits below the unit count, then the lowest byte holding one
    always_comb
    begin
        scan_mask = '0;
        sel_byte  = '0;
        sel_bits  = '0;
        for (int b = 0; b < W; b++)
        begin
            scan_mask[b] = !eff_word[b] && (CMP_W'(b) < scan_rem);
        end
        for (int j = NBYTES - 1; j >= 0; j--)
        begin
            if (|scan_mask[j*BYTE_BITS +: BYTE_BITS])
            begin
                sel_byte = BSEL_W'(j);
                sel_bits = scan_mask[j*BYTE_BITS +: BYTE_BITS];
            end
        end
    end

    always_comb
    begin
        pick_bit = '0;
        for (int b = BYTE_BITS - 1; b >= 0; b--)
        begin
            if (bytebits_reg[b])
            begin
                pick_bit = BYTE_LOG2'(b);
            end
        end
    end

    assign pick_pos = BIT_W'({bytesel_reg, pick_bit});

    always_comb
    begin
        alu_ctrl.op    = ALU_SUB;
        alu_ctrl.shamt = shift_reg;
        alu_a          = addr_reg;
        alu_b          = base_reg;
        unique case (state_reg)
            S_FREE_SHR:
            begin
                alu_ctrl.op = ALU_SHR;
                alu_a       = acc_reg;
            end
            S_ADDR:
            begin
                alu_ctrl.op = ALU_ADD_SHL;
                alu_a       = base_reg;
                alu_b       = {{(DATA_W-UIDX_W){1'b0}}, unit_reg};
            end
            default:
            begin
                alu_ctrl.op = ALU_SUB;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        shift_next      = shift_reg;
        units_next      = units_reg;
        hwm_next        = hwm_reg;
        rsp_valid_next  = rsp_valid_reg;
        n_next          = n_reg;
        addr_next       = addr_reg;
        acc_next        = acc_reg;
        word_next       = word_reg;
        hold_next       = hold_reg;
        bytesel_next    = bytesel_reg;
        bytebits_next   = bytebits_reg;
        unit_next       = unit_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        mem_we          = 1'b0;
        wr_addr         = word_reg;
        wr_data         = hold_reg | bit_onehot;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BASE:  base_next  = cfg.data;
                CFG_SHIFT: shift_next = cfg.data[SHIFT_W-1:0];
                CFG_UNITS: units_next = cfg.data[UNITS_W-1:0];
                default:   ;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    n_next          = n_eff;
                    addr_next       = req.address;
                    word_next       = '0;
                    res_addr_next   = '0;
                    res_status_next = STATUS_OK;
                    state_next      = (req.action == ACT_ALLOC) ? S_SCAN_RD : S_FREE_SUB;
                end
            end
            S_SCAN_RD:
            begin
                if (word_unit >= n_cmp)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                hold_next     = eff_word;
                bytesel_next  = sel_byte;
                bytebits_next = sel_bits;
                if (|scan_mask)
                begin
                    state_next = S_PICK;
                end
                else if (word_unit + CMP_W'(W) >= n_cmp)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_PICK:
            begin
                unit_next  = {word_reg, pick_pos};
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                mem_we        = 1'b1;
                res_addr_next = alu_res;
                if ((WORD_W+1)'(word_reg) >= (WORD_W+1)'(hwm_reg))
                begin
                    hwm_next = HWM_W'((WORD_W+1)'(word_reg) + 1'b1);
                end
                state_next = S_DONE;
            end
            S_FREE_SUB:
            begin
                acc_next = alu_res;
                if (alu_borrow)
                begin
                    res_status_next = STATUS_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FREE_SHR;
                end
            end
            S_FREE_SHR:
            begin
                unit_next = alu_res[UIDX_W-1:0];
                if (alu_res >= DATA_W'(n_reg))
                begin
                    res_status_next = STATUS_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = unit_reg[UIDX_W-1:BIT_W];
                wr_data    = eff_word & ~bit_onehot;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            shift_reg     <= SHIFT_RESET;
            units_reg     <= UNITS_RESET;
            hwm_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            shift_reg     <= shift_next;
            units_reg     <= units_next;
            hwm_reg       <= hwm_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        addr_reg       <= addr_next;
        acc_reg        <= acc_next;
        word_reg       <= word_next;
        hold_reg       <= hold_next;
        bytesel_reg    <= bytesel_next;
        bytebits_reg   <= bytebits_next;
        unit_reg       <= unit_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    // words at or above the fill count were never written by an allocation and read as zero
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= map_mem[rd_addr];
        live_reg  <= (WORD_W+1)'(rd_addr) < (WORD_W+1)'(hwm_reg);
    end

endmodule

>>> src/bba_alu.sv
// Shared 32-bit unit: subtract with borrow, shift-and-add, right shift.
module bba_alu import bba_pkg::*;
(
    input  alu_ctrl_t          ctrl,
    input  logic [DATA_W-1:0]  a,
    input  logic [DATA_W-1:0]  b,
    output logic [DATA_W-1:0]  result,
    output logic               borrow
);

    always_comb
    begin
        result = '0;
        borrow = 1'b0;
        unique case (ctrl.op)
            ALU_SUB:
            begin
                {borrow, result} = {1'b0, a} - {1'b0, b};
            end
            ALU_ADD_SHL:
            begin
                result = a + (b << ctrl.shamt);
            end
            ALU_SHR:
            begin
                result = a >> ctrl.shamt;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

>>> src/bba_checker.sv
// Port-level checks for the allocator, bound to the top level.
module bba_checker import bba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] rsp_unit_address,
    input logic [1:0]        rsp_status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result posted while block was idle");

    a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_OK |-> rsp_unit_address == '0)
        else $error("nonzero address with error status");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_unit_address (rsp.unit_address),
    .rsp_status       (rsp.status)
);

>>> test/tb_top.sv
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 100ps

module tb_top;
    import bba_pkg::*;

    localparam int UNIT_CAP    = (MAX_UNITS_DEF / BYTE_BITS) * BYTE_BITS;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] unit_address;
        status_t           status;
    } grant_t;

    // Tracks the free map and register copies, predicts each grant and checks results.
    class grant_tracker;
        logic [DATA_W-1:0]  base;
        logic [SHIFT_W-1:0] shift;
        logic [UNITS_W-1:0] units;
        bit                 taken [MAX_UNITS_DEF];
        grant_t             grants_due [$];
        int                 errors;
        int                 request_count;
        int                 ok_count;
        int                 full_count;
        int                 range_count;

        function new();
            base  = BASE_RESET;
            shift = SHIFT_RESET;
            units = UNITS_RESET;
        endfunction

        function int unsigned unit_limit();
            int unsigned n;
            n = units;
            n = n & ~32'd7;
            if (n > UNIT_CAP)
                n = UNIT_CAP;
            return n;
        endfunction

        function void write_register(cfg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_BASE:  base  = value;
                CFG_SHIFT: shift = value[SHIFT_W-1:0];
                CFG_UNITS: units = value[UNITS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(action_t act, logic [DATA_W-1:0] addr);
            int unsigned       n;
            int unsigned       u;
            logic [DATA_W-1:0] idx;
            grant_t            res;
            n = unit_limit();
            res.unit_address = '0;
            res.status       = STATUS_OK;
            request_count++;
            if (act == ACT_ALLOC) begin
                u = 0;
                while (u < n && taken[u])
                    u++;
                if (u >= n)
                    res.status = STATUS_FULL;
                else
                begin
                    taken[u] = 1'b1;
                    res.unit_address = base + (DATA_W'(u) << shift);
                end
            end
            else if (addr < base)
                res.status = STATUS_RANGE;
            else
            begin
                // misaligned addresses free the unit that holds them
                idx = (addr - base) >> shift;
                if (idx >= n)
                    res.status = STATUS_RANGE;
                else
                    taken[idx] = 1'b0;
            end
            grants_due.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] ua, status_t st);
            grant_t want;
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result address %h status %0d", ua, st));
                return;
            end
            want = grants_due.pop_front();
            if (ua !== want.unit_address)
                report_mismatch($sformatf("unit_address %h, expected %h",
                                          ua, want.unit_address));
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
            case (want.status)
                STATUS_OK:    ok_count++;
                STATUS_FULL:  full_count++;
                STATUS_RANGE: range_count++;
                default: ;
            endcase
        endtask

        // Random unit inside the searched range whose bit is set, or -1.
        function int pick_taken_unit();
            int unsigned n;
            int unsigned start;
            int unsigned u;
            n = unit_limit();
            if (n == 0)
                return -1;
            start = $urandom_range(0, n - 1);
            for (int unsigned k = 0; k < n; k++) begin
                u = (start + k) % n;
                if (taken[u])
                    return int'(u);
            end
            return -1;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady_flow;
    int   rsp_hold;
    int   cycle_count;

    grant_tracker sb = new();

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();
    bba_cfg_if cfg_ch ();

    bitmap_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Response side back-pressure.
    always @(negedge clk)
    begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 4) == 0)
                rsp_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.action, req_ch.address);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.unit_address, rsp_ch.status);
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.write_register(cfg_index_t'(cfg_ch.index), cfg_ch.data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.grants_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(action_t act, logic [DATA_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.grants_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic configure(logic [DATA_W-1:0] base_value, logic [SHIFT_W-1:0] shift_value,
                             logic [UNITS_W-1:0] units_value);
        cfg_index_t        reg_order [3];
        logic [DATA_W-1:0] value [3];
        reg_order[0] = CFG_BASE;
        reg_order[1] = CFG_SHIFT;
        reg_order[2] = CFG_UNITS;
        value[0] = base_value;
        value[1] = DATA_W'(shift_value);
        value[2] = DATA_W'(units_value);
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= reg_order[i];
            cfg_ch.data  <= value[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int                 r;
        int                 alloc_pct;
        int                 used;
        int unsigned        n;
        logic [DATA_W-1:0]  base_value;
        logic [SHIFT_W-1:0] shift_value;
        logic [UNITS_W-1:0] units_value;

        rst_n          = 1'b0;
        steady_flow    = 1'b0;
        rsp_hold       = 0;
        cycle_count    = 0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_ALLOC;
        req_ch.address = '0;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_BASE;
        cfg_ch.data    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 4 KiB units from address zero
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'h0000_1FFF);     // misaligned, frees unit 1
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'h1000_0000);     // index equal to the count
        send_request(ACT_FREE,  32'h0000_5000);     // unit already free
        send_request(ACT_FREE,  32'hFFFF_FFFF);
        drain();

        // count rounded down to 8, addresses wrap past the top
        configure(32'hFFFF_FFFC, 5'd0, 17'd13);
        repeat (6) send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'h0000_0000);     // below base
        send_request(ACT_FREE,  32'hFFFF_FFFD);
        send_request(ACT_ALLOC, 32'h0000_0000);
        drain();

        configure(32'h0000_0000, 5'd0, 17'd0);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'h0000_0000);
        drain();

        // count above capacity saturates; with a shift of 31 the top address frees unit 0
        configure(32'h8000_0000, 5'd31, 17'h1FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        send_request(ACT_FREE,  32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 32'h0000_0000);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            r = $urandom_range(0, 9);
            base_value = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            r = $urandom_range(0, 9);
            shift_value = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 :
                          (r == 2) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
            r = $urandom_range(0, 9);
            if (r == 0)
                units_value = 17'($urandom_range(65536, 131071));
            else if (r == 1)
                units_value = 17'($urandom_range(8, 31));
            else
                units_value = 17'($urandom_range(1, 40) * 8);
            if (p == PHASES - 1)
                units_value = 17'd8;
            configure(base_value, shift_value, units_value);
            steady_flow = ($urandom_range(0, 3) == 0);
            alloc_pct   = $urandom_range(35, 70);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                n = sb.unit_limit();
                if (r < alloc_pct)
                    send_request(ACT_ALLOC, $urandom);
                else if (r < alloc_pct + (100 - alloc_pct) * 7 / 10) begin
                    used = sb.pick_taken_unit();
                    if (used < 0)
                        send_request(ACT_ALLOC, $urandom);
                    else
                        send_request(ACT_FREE, sb.base + (DATA_W'(used) << sb.shift) +
                                     ($urandom & ((DATA_W'(1) << sb.shift) - 1)));
                end
                else if ($urandom_range(0, 1) == 0)
                    send_request(ACT_FREE, sb.base +
                                 (DATA_W'($urandom_range(0, n + 7)) << sb.shift));
                else
                    send_request(ACT_FREE, $urandom);
            end
            drain();
        end

        repeat (20) @(negedge clk);
        $display("%0d requests under %0d register settings, %0d cycles", sb.request_count,
                 PHASES + 4, cycle_count);
        $display("results: %0d ok, %0d full, %0d out of range",
                 sb.ok_count, sb.full_count, sb.range_count);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
